>>> sv/bfsp_pkg.sv
// shared constants and types for the shortest path block
// no dependencies
package bfsp_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int VIDX_W       = 4;
  localparam int WEIGHT_BITS  = 16;
  localparam int DIST_W       = 32;
  localparam int SUM_W        = DIST_W + 2;
  localparam int COUNT_W      = 5;
  localparam int EDGE_ADDR_W  = 2 * VIDX_W;
  localparam int EDGE_DEPTH   = MAX_VERTICES * MAX_VERTICES;
  localparam int CFG_DATA_W   = 5;

  localparam logic ACTION_LOAD = 1'b0;
  localparam logic ACTION_RUN  = 1'b1;

  localparam logic CFG_VERTEX_COUNT  = 1'b0;
  localparam logic CFG_SOURCE_VERTEX = 1'b1;

  localparam logic [COUNT_W-1:0] VCOUNT_RESET = COUNT_W'(MAX_VERTICES);

  typedef struct packed {
    logic              improve;
    logic [DIST_W-1:0] value;
  } relax_t;

endpackage

>>> sv/bellman_ford_shortest_paths.sv
// top level: edge matrix store, distance store and relaxation sequencer
// depends on bfsp_pkg and bfsp_relax_unit
//
// channel   direction  handshake             payload
// in        input      in_valid / in_ready   action from_vertex to_vertex edge_weight edge_absent
// out       output     out_valid / out_ready vertex_index distance reachable negative_cycle last
// cfg       input      cfg_we                cfg_index cfg_data
//
// a load item writes the edge matrix store and the block stays ready for the next item
// a run item makes n passes over all n*n pairs for n vertices: each pair
// is read from the matrix and distance stores and then relaxed in the shared
// relaxation unit, and each row first fetches the row distance
// then the results are offered one by one, each held until out_ready
// synchronous reset returns to idle with 16 vertices and source 0
module bellman_ford_shortest_paths (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             action,
  input  logic [bfsp_pkg::VIDX_W-1:0]      from_vertex,
  input  logic [bfsp_pkg::VIDX_W-1:0]      to_vertex,
  input  logic [bfsp_pkg::WEIGHT_BITS-1:0] edge_weight,
  input  logic                             edge_absent,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [bfsp_pkg::VIDX_W-1:0]      vertex_index,
  output logic [bfsp_pkg::DIST_W-1:0]      distance,
  output logic                             reachable,
  output logic                             negative_cycle,
  output logic                             last,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [bfsp_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bfsp_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_INIT  = 3'd1;
  localparam logic [2:0] ST_ROW   = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_RELAX = 3'd4;
  localparam logic [2:0] ST_OUTRD = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  logic [2:0]               state;
  logic [COUNT_W-1:0]       vcount;
  logic [VIDX_W-1:0]        src;
  logic [COUNT_W-1:0]       n;
  logic [COUNT_W-1:0]       n_next;
  logic [COUNT_W-1:0]       pass;
  logic [VIDX_W-1:0]        u;
  logic [VIDX_W-1:0]        v;
  logic [DIST_W-1:0]        du;
  logic                     neg;
  logic [MAX_VERTICES-1:0]  vld;

  logic [WEIGHT_BITS:0]     wt_mem [EDGE_DEPTH];
  logic [WEIGHT_BITS:0]     wt_rdata;
  logic [DIST_W-1:0]        dist_mem [MAX_VERTICES];
  logic [DIST_W-1:0]        dist_rdata;
  logic                     dist_rd_en;
  logic [VIDX_W-1:0]        dist_rd_addr;
  logic                     dist_we;
  logic [VIDX_W-1:0]        dist_wr_addr;
  logic [DIST_W-1:0]        dist_wr_data;

  logic                     in_fire;
  logic                     is_check;
  logic                     v_end;
  logic                     u_end;
  logic [COUNT_W-1:0]       n_last;
  relax_t                   rlx;

  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign n_last   = n - COUNT_W'(1);
  assign is_check = (pass == n_last);
  assign v_end    = ({1'b0, v} == n_last);
  assign u_end    = ({1'b0, u} == n_last);

  always_comb begin
    if (vcount == '0) begin
      n_next = COUNT_W'(1);
    end else if (vcount > COUNT_W'(MAX_VERTICES)) begin
      n_next = COUNT_W'(MAX_VERTICES);
    end else begin
      n_next = vcount;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      vcount <= VCOUNT_RESET;
      src    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_VERTEX_COUNT:  vcount <= cfg_data;
        CFG_SOURCE_VERTEX: src    <= cfg_data[VIDX_W-1:0];
        default:           vcount <= vcount;
      endcase
    end
  end

  // edge matrix store
  always_ff @(posedge clk) begin
    if (in_fire && action == ACTION_LOAD) begin
      wt_mem[{from_vertex, to_vertex}] <= {edge_absent, edge_weight};
    end
    wt_rdata <= wt_mem[{u, v}];
  end

  // distance store
  always_comb begin
    dist_rd_en   = (state == ST_ROW) || (state == ST_READ) || (state == ST_OUTRD);
    dist_rd_addr = (state == ST_READ) ? v : u;
    dist_we      = (state == ST_INIT) || (state == ST_RELAX && !is_check && rlx.improve);
    dist_wr_addr = (state == ST_INIT) ? src : v;
    dist_wr_data = (state == ST_INIT) ? '0 : rlx.value;
  end

  always_ff @(posedge clk) begin
    if (dist_we) begin
      dist_mem[dist_wr_addr] <= dist_wr_data;
    end
    if (dist_rd_en) begin
      dist_rdata <= dist_mem[dist_rd_addr];
    end
  end

  bfsp_relax_unit u_relax (
    .du       (du),
    .du_valid (vld[u]),
    .weight   (wt_rdata[WEIGHT_BITS-1:0]),
    .absent   (wt_rdata[WEIGHT_BITS]),
    .dv       (dist_rdata),
    .dv_valid (vld[v]),
    .res      (rlx)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pass  <= '0;
      neg   <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_fire && action == ACTION_RUN) begin
            n     <= n_next;
            state <= ST_INIT;
          end
        end
        ST_INIT: begin
          vld   <= ({1'b0, src} < n) ? (MAX_VERTICES'(1) << src) : '0;
          pass  <= '0;
          neg   <= 1'b0;
          u     <= '0;
          v     <= '0;
          state <= ST_ROW;
        end
        ST_ROW: begin
          state <= ST_READ;
        end
        ST_READ: begin
          if (v == '0) begin
            du <= dist_rdata;
          end
          state <= ST_RELAX;
        end
        ST_RELAX: begin
          if (is_check && rlx.improve) begin
            neg   <= 1'b1;
            state <= ST_OUT;
          end else begin
            if (!is_check && rlx.improve) begin
              vld[v] <= 1'b1;
              if (v == u) begin
                du <= rlx.value;
              end
            end
            if (!v_end) begin
              v     <= v + VIDX_W'(1);
              state <= ST_READ;
            end else if (!u_end) begin
              u     <= u + VIDX_W'(1);
              v     <= '0;
              state <= ST_ROW;
            end else if (is_check) begin
              u     <= '0;
              state <= ST_OUTRD;
            end else begin
              pass  <= pass + COUNT_W'(1);
              u     <= '0;
              v     <= '0;
              state <= ST_ROW;
            end
          end
        end
        ST_OUTRD: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_ready) begin
            if (neg || u_end) begin
              state <= ST_IDLE;
            end else begin
              u     <= u + VIDX_W'(1);
              state <= ST_OUTRD;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // result item, held steady while out_valid is up
  assign out_valid      = (state == ST_OUT);
  assign negative_cycle = neg;
  assign vertex_index   = neg ? '0 : u;
  assign reachable      = !neg && vld[u];
  assign distance       = reachable ? dist_rdata : '0;
  assign last           = neg || u_end;

  a_neg_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && negative_cycle |-> last)
    else $error("negative cycle item not marked last");

  a_neg_not_reachable: assert property (@(posedge clk) disable iff (rst)
    out_valid && reachable |-> !negative_cycle)
    else $error("reachable item during negative cycle report");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while results pending");

  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && action == ACTION_RUN |=> !in_ready && !out_valid)
    else $error("run item did not start the sequencer");

endmodule

>>> sv/bfsp_relax_unit.sv
// shared add, compare and saturate unit for one edge relaxation
// depends on bfsp_pkg
module bfsp_relax_unit (
  input  logic [bfsp_pkg::DIST_W-1:0]      du,
  input  logic                             du_valid,
  input  logic [bfsp_pkg::WEIGHT_BITS-1:0] weight,
  input  logic                             absent,
  input  logic [bfsp_pkg::DIST_W-1:0]      dv,
  input  logic                             dv_valid,
  output bfsp_pkg::relax_t                 res
);
  import bfsp_pkg::*;

  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] dv_ext;
  logic                    less;
  logic                    in_range;

  always_comb begin
    sum      = $signed({{(SUM_W-DIST_W){du[DIST_W-1]}}, du})
             + $signed({{(SUM_W-WEIGHT_BITS){weight[WEIGHT_BITS-1]}}, weight});
    dv_ext   = $signed({{(SUM_W-DIST_W){dv[DIST_W-1]}}, dv});
    less     = sum < dv_ext;
    in_range = (sum[SUM_W-1:DIST_W-1] == '0) || (sum[SUM_W-1:DIST_W-1] == '1);
    res.improve = du_valid && !absent && (!dv_valid || less);
    if (in_range) begin
      res.value = sum[DIST_W-1:0];
    end else if (sum[SUM_W-1]) begin
      res.value = {1'b1, {(DIST_W-1){1'b0}}};
    end else begin
      res.value = {1'b0, {(DIST_W-1){1'b1}}};
    end
  end

endmodule
